/* rtl/bhds_pkg.sv */
// Package: SHA-256 constants, types and round functions for the double-hash pipeline.
`default_nettype none
package bhds_pkg;

  localparam int unsigned NumRounds = 64;
  localparam int unsigned CfgAddrW = 6;

  localparam logic [CfgAddrW-1:0] RegMid01 = 6'h00;
  localparam logic [CfgAddrW-1:0] RegMid23 = 6'h08;
  localparam logic [CfgAddrW-1:0] RegMid45 = 6'h10;
  localparam logic [CfgAddrW-1:0] RegMid67 = 6'h18;
  localparam logic [CfgAddrW-1:0] RegMerkle = 6'h20;
  localparam logic [CfgAddrW-1:0] RegTime = 6'h28;
  localparam logic [CfgAddrW-1:0] RegDiff = 6'h30;

  localparam logic [31:0] PadWord = 32'h80000000;
  localparam logic [31:0] Len1Word = 32'h00000280;
  localparam logic [31:0] Len2Word = 32'h00000100;
  localparam logic [15:0] HitMask = 16'hffff;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] state_t;
  typedef word_t [15:0] sched_t;

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam state_t InitH = '{
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic word_t rotr(input word_t v, input int unsigned s);
    return (v >> s) | (v << (32 - s));
  endfunction

  function automatic word_t bswap(input word_t v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  // one round: state index 0 is a, 7 is h
  function automatic state_t sha_round(input state_t v, input word_t kw);
    word_t t1;
    word_t t2;
    state_t r;
    t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
         ((v[4] & v[5]) ^ (~v[4] & v[6])) + kw;
    t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
         ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    r[7] = v[6]; r[6] = v[5]; r[5] = v[4]; r[4] = v[3] + t1;
    r[3] = v[2]; r[2] = v[1]; r[1] = v[0]; r[0] = t1 + t2;
    return r;
  endfunction

  // shift the 16-word schedule window by one
  function automatic sched_t sched_step(input sched_t w);
    word_t s0;
    word_t s1;
    sched_t r;
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    for (int i = 0; i < 15; i++) r[i] = w[i+1];
    r[15] = w[0] + s0 + w[9] + s1;
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/bhds_if.sv */
// Valid/ready channel interfaces for nonce words and result words.
`default_nettype none
interface bhds_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] nonce_word;
  modport source (output valid, output nonce_word, input ready);
  modport sink (input valid, input nonce_word, output ready);
endinterface

interface bhds_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] nonce_echo;
  logic        hit;
  logic [31:0] digest_w0;
  logic [31:0] digest_w1;
  logic [31:0] digest_w2;
  logic [31:0] digest_w3;
  logic [31:0] digest_w4;
  logic [31:0] digest_w5;
  logic [31:0] digest_w6;
  logic [31:0] digest_w7;
  modport source (output valid, output nonce_echo, output hit, output digest_w0,
                  output digest_w1, output digest_w2, output digest_w3, output digest_w4,
                  output digest_w5, output digest_w6, output digest_w7, input ready);
  modport sink (input valid, input nonce_echo, input hit, input digest_w0,
                input digest_w1, input digest_w2, input digest_w3, input digest_w4,
                input digest_w5, input digest_w6, input digest_w7, output ready);
endinterface
`default_nettype wire

/* rtl/bhds_compress.sv */
// Fully unrolled SHA-256 compression, one registered stage per round.
`default_nettype none
module bhds_compress
  import bhds_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   adv,
  input  wire logic   in_vld,
  input  wire state_t in_st,
  input  wire sched_t in_msg,
  input  wire word_t  in_tag,
  output logic        out_vld,
  output state_t      out_st,
  output word_t       out_tag
);

  logic   vld_r [NumRounds];
  state_t st_r  [NumRounds];
  state_t h0_r  [NumRounds];
  sched_t w_r   [NumRounds-1];
  word_t  tag_r [NumRounds];

  for (genvar g = 0; g < NumRounds; g++) begin : g_rnd
    logic   cur_vld;
    state_t cur_st;
    state_t cur_h0;
    sched_t cur_w;
    word_t  cur_tag;

    if (g == 0) begin : g_first
      assign cur_vld = in_vld;
      assign cur_st = in_st;
      assign cur_h0 = in_st;
      assign cur_w = in_msg;
      assign cur_tag = in_tag;
    end else begin : g_next
      assign cur_vld = vld_r[g-1];
      assign cur_st = st_r[g-1];
      assign cur_h0 = h0_r[g-1];
      assign cur_w = w_r[g-1];
      assign cur_tag = tag_r[g-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (adv) begin
        vld_r[g] <= cur_vld;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[g] <= sha_round(cur_st, RoundK[g] + cur_w[0]);
        h0_r[g] <= cur_h0;
        tag_r[g] <= cur_tag;
      end
    end

    if (g < NumRounds - 1) begin : g_sched
      always_ff @(posedge clk) begin
        if (adv) begin
          w_r[g] <= sched_step(cur_w);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) out_st[i] = st_r[NumRounds-1][i] + h0_r[NumRounds-1][i];
  end
  assign out_vld = vld_r[NumRounds-1];
  assign out_tag = tag_r[NumRounds-1];

endmodule
`default_nettype wire

/* rtl/block_header_double_sha256_top.sv */
// Top level: config registers, two chained compression pipelines and output stage.
// Takes one nonce word per cycle unless the output stalls; each nonce passes through
// two 64-round unrolled compression pipelines plus a feed and an output register.
// The whole pipeline advances together and holds when the output word is not taken.
`default_nettype none
module block_header_double_sha256_top
  import bhds_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  bhds_in_if.sink                  in_ch,
  bhds_out_if.source               out_ch,
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [CfgAddrW-1:0] cfg_paddr,
  input  wire logic [63:0]         cfg_pwdata,
  output logic [63:0]              cfg_prdata,
  output logic                     cfg_pready
);

  logic [63:0] mid_r [4];
  word_t merkle_r, time_r, diff_r;
  logic wr;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) mid_r[i] <= '0;
      merkle_r <= '0; time_r <= '0; diff_r <= '0;
    end else if (wr) begin
      case (cfg_paddr)
        RegMid01: mid_r[0] <= cfg_pwdata;
        RegMid23: mid_r[1] <= cfg_pwdata;
        RegMid45: mid_r[2] <= cfg_pwdata;
        RegMid67: mid_r[3] <= cfg_pwdata;
        RegMerkle: merkle_r <= cfg_pwdata[31:0];
        RegTime: time_r <= cfg_pwdata[31:0];
        RegDiff: diff_r <= cfg_pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr)
      RegMid01: cfg_prdata = mid_r[0];
      RegMid23: cfg_prdata = mid_r[1];
      RegMid45: cfg_prdata = mid_r[2];
      RegMid67: cfg_prdata = mid_r[3];
      RegMerkle: cfg_prdata = {32'h0, merkle_r};
      RegTime: cfg_prdata = {32'h0, time_r};
      RegDiff: cfg_prdata = {32'h0, diff_r};
      default: cfg_prdata = '0;
    endcase
  end

  // pipeline advances when the output register is empty or being drained
  logic out_vld_r, adv;
  assign adv = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  state_t mid_st;
  sched_t msg1;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mid_st[2*i] = mid_r[i][63:32];
      mid_st[2*i+1] = mid_r[i][31:0];
    end
    msg1 = '0;
    msg1[0] = merkle_r;
    msg1[1] = time_r;
    msg1[2] = diff_r;
    msg1[3] = in_ch.nonce_word;
    msg1[4] = PadWord;
    msg1[15] = Len1Word;
  end

  logic   v1;
  state_t st1;
  word_t  tag1;
  bhds_compress u_c1 (
    .clk, .rst_n, .adv,
    .in_vld(in_ch.valid), .in_st(mid_st), .in_msg(msg1), .in_tag(in_ch.nonce_word),
    .out_vld(v1), .out_st(st1), .out_tag(tag1)
  );

  // register between the two hashes to cut the final add from round one
  logic   v2_r;
  state_t st2_r;
  word_t  tag2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      st2_r <= st1;
      tag2_r <= tag1;
    end
  end

  sched_t msg2;
  always_comb begin
    msg2 = '0;
    for (int i = 0; i < 8; i++) msg2[i] = st2_r[i];
    msg2[8] = PadWord;
    msg2[15] = Len2Word;
  end

  logic   v3;
  state_t st3;
  word_t  tag3;
  bhds_compress u_c2 (
    .clk, .rst_n, .adv,
    .in_vld(v2_r), .in_st(InitH), .in_msg(msg2), .in_tag(tag2_r),
    .out_vld(v3), .out_st(st3), .out_tag(tag3)
  );

  state_t dig_r;
  word_t  nonce_r;
  logic   hit_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= v3;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 8; i++) dig_r[i] <= bswap(st3[i]);
      nonce_r <= tag3;
      hit_r <= (st3[7][15:0] & HitMask) == 16'h0;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.nonce_echo = nonce_r;
  assign out_ch.hit = hit_r;
  assign out_ch.digest_w0 = dig_r[0];
  assign out_ch.digest_w1 = dig_r[1];
  assign out_ch.digest_w2 = dig_r[2];
  assign out_ch.digest_w3 = dig_r[3];
  assign out_ch.digest_w4 = dig_r[4];
  assign out_ch.digest_w5 = dig_r[5];
  assign out_ch.digest_w6 = dig_r[6];
  assign out_ch.digest_w7 = dig_r[7];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> out_vld_r && $stable(nonce_r) && $stable(dig_r))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ch.ready)
    else $error("input stalled with empty output");
  a_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> hit_r == (dig_r[7][31:16] == 16'h0))
    else $error("hit flag inconsistent with digest");

endmodule
`default_nettype wire
